>>> rtl/lkvc_pkg.sv
// Package for the LRU key-value cache: field widths, action codes and reset constants.
// No dependencies; the cache and its checker import it.
`default_nettype none

package lkvc_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_W           = 32;
   localparam int CSR_W            = 5;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   localparam logic [CSR_W-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE     = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] PUT_VALUE      = {DATA_W{1'b0}};

endpackage

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg for widths, action codes and reset constants.
`default_nettype none

// The cache holds up to CAPACITY key/value pairs in flip-flops and compares a
// request's key with every valid entry at once. A get returns the stored value
// with found set, or -1 with found clear; a put updates a present key, fills
// the lowest free slot while fewer than capacity_in_use entries are valid, and
// otherwise replaces the least recently used entry. Every entry carries an age
// rank (0 is the most recent), so the replacement victim is simply the valid
// entry whose rank is one below the fill count. An accepted item is held in
// the request register, is resolved against the entry table while it is
// there, and its result is registered in the response register. With
// rsp_ready held high, one item is accepted and one result delivered
// every cycle. The table update of one item completes before the next item is
// resolved, so back-to-back requests always see each other's effects. After
// reset all entries are invalid and capacity_in_use is 16; a value of 0 acts
// as 1 and a value above CAPACITY acts as CAPACITY. Lowering the capacity never
// drops entries, it only makes a new key evict sooner. The capacity register
// may only be written while the cache is idle; csr_ready is always high.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   // configuration channel
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [CSR_W-1:0]        csr_capacity_in_use,
   // request channel
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire                     req_action,
   input  wire  signed [DATA_W-1:0] req_lookup_key,
   input  wire  signed [DATA_W-1:0] req_write_value,
   // response channel
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic                    rsp_found,
   output logic signed [DATA_W-1:0] rsp_read_value
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W = $clog2(CAPACITY);
   localparam int CMP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   // Configuration.
   logic [CSR_W-1:0] capacity_ff;

   // Request register.
   logic              s1_valid_ff;
   logic              s1_action_ff;
   logic [DATA_W-1:0] s1_key_ff;
   logic [DATA_W-1:0] s1_value_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic              rsp_found_ff,  rsp_found_in;
   logic [DATA_W-1:0] rsp_value_ff,  rsp_value_in;

   // Entry table.
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [DATA_W-1:0]   key_ff   [CAPACITY];
   logic [DATA_W-1:0]   value_ff [CAPACITY];
   logic [RANK_W-1:0]   rank_ff  [CAPACITY];
   logic [RANK_W-1:0]   rank_in  [CAPACITY];
   logic [CNT_W-1:0]    count_ff, count_in;

   // Lookup and update control.
   logic                advance;
   logic                process;
   logic                is_put;
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] hit_oh;
   logic [CAPACITY-1:0] free_oh;
   logic [CAPACITY-1:0] victim_oh;
   logic [CAPACITY-1:0] target_oh;
   logic                hit;
   logic                full;
   logic                update;
   logic [DATA_W-1:0]   hit_value;
   logic [RANK_W-1:0]   hit_rank;
   logic [CNT_W-1:0]    old_rank;
   logic [CNT_W-1:0]    count_m1;
   logic [CMP_W-1:0]    cap_ext;
   logic [CMP_W-1:0]    cap_eff;

   assign csr_ready = 1'b1;

   // The response register drains or is empty: the request register may move.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign process   = s1_valid_ff && advance;
   assign is_put    = (s1_action_ff == ACT_PUT);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // Effective capacity: zero acts as one, anything above CAPACITY is clipped.
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (capacity_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(CAPACITY)) begin
         cap_eff = CMP_W'(CAPACITY);
      end else begin
         cap_eff = cap_ext;
      end
      full     = (CMP_W'(count_ff) >= cap_eff);
      count_m1 = count_ff - CNT_W'(1);
   end

   // Parallel key match, lowest free slot and least recently used entry.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i]     = valid_ff[i] && (key_ff[i] == s1_key_ff);
         victim_oh[i] = valid_ff[i] && (CNT_W'(rank_ff[i]) == count_m1);
      end
      hit_oh  = match & (~match + CAPACITY'(1));
      free_oh = ~valid_ff & (valid_ff + CAPACITY'(1));
      hit     = |match;

      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_value = hit_value | ({DATA_W{hit_oh[i]}} & value_ff[i]);
         hit_rank  = hit_rank  | ({RANK_W{hit_oh[i]}} & rank_ff[i]);
      end

      // The slot that becomes most recent, and the rank it held before.
      if (hit) begin
         target_oh = hit_oh;
         old_rank  = CNT_W'(hit_rank);
      end else if (!full) begin
         target_oh = free_oh;
         old_rank  = count_ff;
      end else begin
         target_oh = victim_oh;
         old_rank  = count_m1;
      end
      update = process && (is_put || hit);
   end

   // Next state of the table and of the response.
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         rank_in[i] = rank_ff[i];
         if (update) begin
            if (target_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (CNT_W'(rank_ff[i]) < old_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      if (process && is_put) begin
         valid_in = valid_ff | target_oh;
         if (!hit && !full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      rsp_found_in = hit;
      if (is_put) begin
         rsp_value_in = PUT_VALUE;
      end else if (hit) begin
         rsp_value_in = hit_value;
      end else begin
         rsp_value_in = MISS_VALUE;
      end
   end

   // Control state and age ranks.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity_in_use;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Payload registers: keys, values, request and response data.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_action_ff <= req_action;
         s1_key_ff    <= req_lookup_key;
         s1_value_ff  <= req_write_value;
      end
      if (process) begin
         rsp_found_ff <= rsp_found_in;
         rsp_value_ff <= rsp_value_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (process && is_put && target_oh[i]) begin
            key_ff[i]   <= s1_key_ff;
            value_ff[i] <= s1_value_ff;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to its top level.
// Depends on lkvc_pkg and on the port list of lru_key_value_cache.
`default_nettype none

module lkvc_checker
   import lkvc_pkg::*;
(
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input wire              rsp_found,
   input wire [DATA_W-1:0] rsp_read_value
);

   // A stalled result keeps its item unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_read_value))
      else $error("stalled response changed");

   // A result without found is a get miss (all ones) or a put (zero).
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_read_value == MISS_VALUE) ||
                                  (rsp_read_value == PUT_VALUE))
      else $error("miss response carries a stored value");

   // A new result traces back through the request and response registers to a taken item.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without an accepted request");

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_found      (rsp_found),
   .rsp_read_value (rsp_read_value)
);

`default_nettype wire

>>> sim/lru_key_value_cache_checker.sv
`timescale 1ns / 100ps
// Checker for the LRU key-value cache: keeps its own copy of the entry table,
// predicts each reply and compares it with what the cache returns.
// Depends on lkvc_pkg for widths, action codes and reset constants.

module lru_key_value_cache_checker
   import lkvc_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_valid,
   input  wire                     csr_ready,
   input  wire  [CSR_W-1:0]        csr_capacity_in_use,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  wire                     req_action,
   input  wire  [DATA_W-1:0]       req_lookup_key,
   input  wire  [DATA_W-1:0]       req_write_value,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  wire                     rsp_found,
   input  wire  [DATA_W-1:0]       rsp_read_value,
   output int                      mismatch_count,
   output int                      replies_outstanding
);

   localparam int SLOTS = CAPACITY_DEFAULT;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] value;
   } reply_type;

   logic              slot_used [SLOTS];
   logic [DATA_W-1:0] slot_key  [SLOTS];
   logic [DATA_W-1:0] slot_data [SLOTS];
   int                slot_rank [SLOTS];
   int                fill_count;
   logic [CSR_W-1:0]  capacity_limit;
   reply_type         predicted_replies [$];

   // Zero acts as one entry, anything above the table size as the full table.
   function automatic int usable_slots();
      int c;
      c = int'(capacity_limit);
      if (c == 0) return 1;
      if (c > SLOTS) return SLOTS;
      return c;
   endfunction

   // Slot s becomes rank 0; every valid entry younger than its old rank ages by one.
   function automatic void refresh_age(int s, int old_rank);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
      end
      slot_rank[s] = 0;
   endfunction

   function automatic reply_type predict_reply(logic action, logic [DATA_W-1:0] key,
                                               logic [DATA_W-1:0] data);
      int        hit_slot;
      int        free_slot;
      int        victim;
      int        oldest;
      reply_type r;
      hit_slot  = -1;
      free_slot = -1;
      victim    = -1;
      oldest    = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit_slot < 0 && slot_used[i] && slot_key[i] == key) hit_slot = i;
      end
      if (action == ACT_GET) begin
         if (hit_slot >= 0) begin
            r.found = 1'b1;
            r.value = slot_data[hit_slot];
            refresh_age(hit_slot, slot_rank[hit_slot]);
         end else begin
            r.found = 1'b0;
            r.value = MISS_VALUE;
         end
         return r;
      end
      r.found = (hit_slot >= 0);
      r.value = PUT_VALUE;
      if (hit_slot >= 0) begin
         slot_data[hit_slot] = data;
         refresh_age(hit_slot, slot_rank[hit_slot]);
      end else if (fill_count < usable_slots()) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
         end
         refresh_age(free_slot, fill_count);
         slot_used[free_slot] = 1'b1;
         slot_key[free_slot]  = key;
         slot_data[free_slot] = data;
         fill_count++;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_rank[i] > oldest) begin
               oldest = slot_rank[i];
               victim = i;
            end
         end
         if (victim >= 0) begin
            slot_key[victim]  = key;
            slot_data[victim] = data;
            refresh_age(victim, oldest);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type due;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_data[i] = '0;
            slot_rank[i] = 0;
         end
         fill_count     = 0;
         capacity_limit = CAPACITY_RESET;
         mismatch_count = 0;
         predicted_replies.delete();
      end else begin
         if (csr_valid && csr_ready) capacity_limit = csr_capacity_in_use;
         if (req_valid && req_ready) begin
            predicted_replies.push_back(predict_reply(req_action, req_lookup_key,
                                                      req_write_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $error("reply with none predicted: found %0b, read_value %0d",
                      rsp_found, $signed(rsp_read_value));
               mismatch_count++;
            end else begin
               due = predicted_replies.pop_front();
               if (rsp_found !== due.found) begin
                  $error("found: expected %0b, got %0b", due.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_read_value !== due.value) begin
                  $error("read_value: expected %0d, got %0d",
                         $signed(due.value), $signed(rsp_read_value));
                  mismatch_count++;
               end
            end
         end
      end
      replies_outstanding = predicted_replies.size();
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the LRU key-value cache testbench: clock, reset, stimulus and verdict.
// Depends on lkvc_pkg, lru_key_value_cache and lru_key_value_cache_checker.

module testbench
   import lkvc_pkg::*;
();

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_W-1:0]         csr_capacity_in_use;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_action;
   logic signed [DATA_W-1:0] req_lookup_key;
   logic signed [DATA_W-1:0] req_write_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_read_value;
   int                       mismatch_count;
   int                       replies_outstanding;

   // When calm is set neither side inserts gaps, so the cache runs at full rate.
   logic                     calm;
   logic [DATA_W-1:0]        key_pool [20];

   lru_key_value_cache #(
      .CAPACITY(CAPACITY_DEFAULT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity_in_use(csr_capacity_in_use),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_lookup_key(req_lookup_key),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_read_value(rsp_read_value)
   );

   lru_key_value_cache_checker u_checker (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity_in_use(csr_capacity_in_use),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_lookup_key(req_lookup_key),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_read_value(rsp_read_value),
      .mismatch_count(mismatch_count),
      .replies_outstanding(replies_outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Gap lengths: mostly none, often short, now and then a long stall.
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Keys are drawn mostly from a small pool so that gets hit, puts update
   // present entries and the table fills up and evicts. The rest are fully
   // random so every key bit is exercised.
   function automatic logic [DATA_W-1:0] pick_key();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return key_pool[$urandom_range(0, 19)];
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h8000_0000;
      if (r == 1) return 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   // Presents one item after an optional gap and holds it until accepted.
   // Inputs move only at falling edges; acceptance is judged at rising edges.
   task automatic send_request(logic action, logic [DATA_W-1:0] key,
                               logic [DATA_W-1:0] data);
      int gap;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_lookup_key  <= key;
      req_write_value <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // The capacity register is only written with the cache idle: the request
   // channel is quiet, every predicted reply has come back, and a further
   // wait lets the request and response registers drain.
   task automatic set_capacity(logic [CSR_W-1:0] capacity);
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_outstanding != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_valid           <= 1'b1;
      csr_capacity_in_use <= capacity;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reply side: ready drops for random stretches unless the phase is calm.
   initial begin
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         hold = idle_len();
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Capacities for the random phases: the extremes (zero, one, the table
   // size, the largest register value) and values in between, including
   // drops below the number of entries already held.
   localparam logic [CSR_W-1:0] PHASE_CAPACITY [10] =
      '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd17, 5'd2, 5'd5, 5'd16};

   initial begin
      calm                = 1'b1;
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_capacity_in_use = '0;
      req_valid           = 1'b0;
      req_action          = ACT_GET;
      req_lookup_key      = '0;
      req_write_value     = '0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 20; i++) key_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity. A get on the empty table misses;
      // its write value must be ignored.
      send_request(ACT_GET, 32'h0000_0000, 32'h1234_5678);
      // Extreme keys and values go in, then every one of them is read back.
      send_request(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(ACT_GET, 32'h0000_0000, 32'h5555_5555);
      send_request(ACT_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
      send_request(ACT_GET, 32'h1234_5678, 32'h0000_0000);
      // A put on a present key only rewrites its value.
      send_request(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
      send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);

      // Capacity lowered below the four entries held: nothing is dropped,
      // but each new key now replaces the least recently used entry.
      set_capacity(5'd2);
      send_request(ACT_PUT, 32'h0000_0064, 32'h0000_0001);
      send_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(ACT_GET, 32'h0000_0064, 32'h0000_0000);
      send_request(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);

      // A capacity of zero behaves as one entry.
      set_capacity(5'd0);
      send_request(ACT_PUT, 32'h0000_00C8, 32'h0000_0002);
      send_request(ACT_PUT, 32'h0000_012C, 32'h0000_0003);
      send_request(ACT_GET, 32'h0000_00C8, 32'h0000_0000);
      send_request(ACT_GET, 32'h0000_012C, 32'h0000_0000);

      // Random phases, each at its own capacity; every third runs without gaps.
      for (int p = 0; p < 10; p++) begin
         set_capacity(PHASE_CAPACITY[p]);
         calm = (p % 3 == 0);
         for (int n = 0; n < 160; n++) begin
            send_request($urandom_range(0, 1) ? ACT_PUT : ACT_GET, pick_key(),
                         pick_value());
         end
      end

      // Drain: wait for the last reply, then wait on for stray output.
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lru_key_value_cache: match");
      end else begin
         $display("lru_key_value_cache: mismatch");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("lru_key_value_cache: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
sim/lru_key_value_cache_checker.sv
sim/testbench.sv
